FILE: sv/card_scan_presence_qualifier_defines.svh
// ----------------------------------------------------------------------------
// Card scan presence qualifier: assertion macros
// Shared assertion forms for the checker; clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef CARD_SCAN_PRESENCE_QUALIFIER_DEFINES_SVH
`define CARD_SCAN_PRESENCE_QUALIFIER_DEFINES_SVH

// Same-cycle implication.
`define CSPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cspq_pkg.sv
// ----------------------------------------------------------------------------
// cspq_pkg
// Types, codes and constants of the card scan presence qualifier.
// ----------------------------------------------------------------------------
package cspq_pkg;

    localparam int IC_UID_BYTES   = 4;
    localparam int ID_UID_BYTES   = 8;
    localparam int NFC_UID_BYTES  = 8;
    localparam int NFC_SLOT_COUNT = 1;

    localparam int UID_W = 64;

    typedef enum logic [1:0] {
        MODE_IC  = 2'd0,
        MODE_ID  = 2'd1,
        MODE_NFC = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_IC  = 2'd0,
        KIND_CPU = 2'd1,
        KIND_ID  = 2'd2,
        KIND_NFC = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CHG_NONE  = 2'd0,
        CHG_ENTER = 2'd1,
        CHG_EXIT  = 2'd2
    } change_t;

    typedef enum logic [2:0] {
        CFG_MULTI_TYPE_ENABLE = 3'd0,
        CFG_IC_SLOT_START     = 3'd1,
        CFG_IC_SLOT_COUNT     = 3'd2,
        CFG_ID_SLOT_COUNT     = 3'd3,
        CFG_IC_HOLD_TICKS     = 3'd4,
        CFG_ID_HOLD_TICKS     = 3'd5,
        CFG_NFC_HOLD_TICKS    = 3'd6,
        CFG_ID_MISS_LIMIT     = 3'd7
    } cfg_idx_t;

    // Presence bit positions
    localparam int PRES_IC  = 0;
    localparam int PRES_ID  = 1;
    localparam int PRES_NFC = 2;

    function automatic int clamp_bytes(input int n);
        int r;
        r = n;
        if (r < 1) r = 1;
        if (r > 8) r = 8;
        return r;
    endfunction

    function automatic logic [UID_W-1:0] byte_mask(input int n);
        int c;
        c = clamp_bytes(n);
        if (c >= 8) return '1;
        return (UID_W'(1) << (8 * c)) - UID_W'(1);
    endfunction

    localparam logic [UID_W-1:0] IC_MASK  = byte_mask(IC_UID_BYTES);
    localparam logic [UID_W-1:0] ID_MASK  = byte_mask(ID_UID_BYTES);
    localparam logic [UID_W-1:0] NFC_MASK = byte_mask(NFC_UID_BYTES);

    localparam logic [3:0] IC_NBYTES  = 4'(clamp_bytes(IC_UID_BYTES));
    localparam logic [3:0] ID_NBYTES  = 4'(clamp_bytes(ID_UID_BYTES));
    localparam logic [3:0] NFC_NBYTES = 4'(clamp_bytes(NFC_UID_BYTES));

    localparam logic [9:0] NFC_SLOTS = 10'(NFC_SLOT_COUNT);

    typedef struct packed {
        logic             scan_ok;
        logic [UID_W-1:0] scanned_uid;
        logic             rats_capable;
    } in_t;

    typedef struct packed {
        logic [1:0]       scan_mode;
        logic             card_event;
        logic [1:0]       card_kind;
        logic [3:0]       card_bytes;
        logic [UID_W-1:0] event_uid;
        logic [2:0]       presence_flags;
        logic [1:0]       presence_change;
    } out_t;

    typedef struct packed {
        logic       multi_type_enable;
        logic [7:0] ic_slot_start;
        logic [7:0] ic_slot_count;
        logic [7:0] id_slot_count;
    } slot_cfg_t;

endpackage

FILE: sv/cspq_sched.sv
// ----------------------------------------------------------------------------
// cspq_sched
// Slot counter and scan mode rotation: IC, ID, NFC, or IC only.
// ----------------------------------------------------------------------------
module cspq_sched (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  cspq_pkg::slot_cfg_t cfg,
    output cspq_pkg::mode_t     mode
);

    logic [7:0]      slot_counter_reg;
    logic [7:0]      slot_counter_next;
    cspq_pkg::mode_t mode_reg;
    cspq_pkg::mode_t mode_next;

    logic [9:0] b0;
    logic [9:0] b1;
    logic [9:0] b2;
    logic [9:0] b3;
    logic [7:0] slot_inc;
    logic [9:0] slot_ext;

    // Boundaries are summed without wrap; one above 255 never matches.
    assign b0       = {2'b00, cfg.ic_slot_start};
    assign b1       = b0 + {2'b00, cfg.ic_slot_count};
    assign b2       = b1 + {2'b00, cfg.id_slot_count};
    assign b3       = b2 + cspq_pkg::NFC_SLOTS;
    assign slot_inc = slot_counter_reg + 8'd1;
    assign slot_ext = {2'b00, slot_inc};

    always_comb
    begin
        slot_counter_next = slot_counter_reg;
        mode_next         = mode_reg;
        if (cfg.multi_type_enable)
        begin
            slot_counter_next = slot_inc;
            priority if (slot_ext == b0)
            begin
                mode_next = cspq_pkg::MODE_IC;
            end
            else if (slot_ext == b1)
            begin
                mode_next = cspq_pkg::MODE_ID;
            end
            else if (slot_ext == b2)
            begin
                mode_next         = cspq_pkg::MODE_NFC;
                slot_counter_next = '0;
            end
            else if (slot_ext >= b3)
            begin
                slot_counter_next = '0;
            end
        end
        else
        begin
            mode_next = cspq_pkg::MODE_IC;
        end
    end

    assign mode = mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_counter_reg <= '0;
            mode_reg         <= cspq_pkg::MODE_IC;
        end
        else if (adv)
        begin
            slot_counter_reg <= slot_counter_next;
            mode_reg         <= mode_next;
        end
    end

endmodule

FILE: sv/card_scan_presence_qualifier.sv
// Path: an input transfer passes the input register, then the result register, to its result.
// Throughput: one scan tick per cycle while the output is not stalled; state updates once per tick.
// Output stall back-pressures the input only when both registers hold items.
// Reset (rst_n low, asynchronous): registers take their documented defaults,
// timers, counters, last UID and presence clear, scan mode returns to IC.
// ----------------------------------------------------------------------------
// card_scan_presence_qualifier
// Qualifies scan ticks into card events and presence enter/exit reports.
// ----------------------------------------------------------------------------
module card_scan_presence_qualifier (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  cspq_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output cspq_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [7:0]      cfg_data
);

    // Configuration registers
    cspq_pkg::slot_cfg_t slot_cfg_reg;
    logic [7:0] ic_hold_ticks_reg;
    logic [7:0] id_hold_ticks_reg;
    logic [7:0] nfc_hold_ticks_reg;
    logic [7:0] id_miss_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cfg_reg.multi_type_enable <= 1'b1;
            slot_cfg_reg.ic_slot_start     <= 8'd1;
            slot_cfg_reg.ic_slot_count     <= 8'd1;
            slot_cfg_reg.id_slot_count     <= 8'd1;
            ic_hold_ticks_reg              <= 8'd16;
            id_hold_ticks_reg              <= 8'd16;
            nfc_hold_ticks_reg             <= 8'd16;
            id_miss_limit_reg              <= 8'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cspq_pkg::CFG_MULTI_TYPE_ENABLE: slot_cfg_reg.multi_type_enable <= cfg_data[0];
                cspq_pkg::CFG_IC_SLOT_START:     slot_cfg_reg.ic_slot_start     <= cfg_data;
                cspq_pkg::CFG_IC_SLOT_COUNT:     slot_cfg_reg.ic_slot_count     <= cfg_data;
                cspq_pkg::CFG_ID_SLOT_COUNT:     slot_cfg_reg.id_slot_count     <= cfg_data;
                cspq_pkg::CFG_IC_HOLD_TICKS:     ic_hold_ticks_reg              <= cfg_data;
                cspq_pkg::CFG_ID_HOLD_TICKS:     id_hold_ticks_reg              <= cfg_data;
                cspq_pkg::CFG_NFC_HOLD_TICKS:    nfc_hold_ticks_reg             <= cfg_data;
                cspq_pkg::CFG_ID_MISS_LIMIT:     id_miss_limit_reg              <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // Handshake: input register then result register
    logic           in_valid_reg;
    cspq_pkg::in_t  in_data_reg;
    logic           out_valid_reg;
    cspq_pkg::out_t out_data_reg;
    cspq_pkg::out_t out_data_next;
    logic           out_ready;
    logic           adv;

    assign out_ready = !out_valid_reg || !out_stall;
    assign adv       = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Mode for this tick
    cspq_pkg::mode_t mode;

    cspq_sched u_sched (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .cfg   (slot_cfg_reg),
        .mode  (mode)
    );

    // Qualification state
    logic [7:0]                 ic_hold_reg,  ic_hold_next;
    logic [7:0]                 id_hold_reg,  id_hold_next;
    logic [7:0]                 nfc_hold_reg, nfc_hold_next;
    logic [7:0]                 id_miss_reg,  id_miss_next;
    logic [cspq_pkg::UID_W-1:0] last_uid_reg, last_uid_next;
    logic [2:0]                 present_reg,  present_next;

    logic [7:0]                 ic_dec;
    logic [7:0]                 id_dec;
    logic [7:0]                 nfc_dec;
    logic [7:0]                 miss_dec;
    logic [7:0]                 timer_sel;
    logic [cspq_pkg::UID_W-1:0] mask_sel;
    logic [cspq_pkg::UID_W-1:0] uid;
    logic                       ok;
    logic                       uid_same;
    logic                       hit_ev;
    cspq_pkg::kind_t            kind;
    logic [3:0]                 nbytes;

    assign ok       = in_data_reg.scan_ok;
    assign uid      = in_data_reg.scanned_uid;
    assign ic_dec   = (ic_hold_reg  == 8'd0) ? 8'd0 : ic_hold_reg  - 8'd1;
    assign id_dec   = (id_hold_reg  == 8'd0) ? 8'd0 : id_hold_reg  - 8'd1;
    assign nfc_dec  = (nfc_hold_reg == 8'd0) ? 8'd0 : nfc_hold_reg - 8'd1;
    assign miss_dec = (id_miss_reg  == 8'd0) ? 8'd0 : id_miss_reg  - 8'd1;
    assign uid_same = ((uid ^ last_uid_reg) & mask_sel) == '0;
    // Repeat of the last UID counts only once its hold-off has run out
    assign hit_ev   = ok && (!uid_same || timer_sel == 8'd0);

    always_comb
    begin
        ic_hold_next  = ic_dec;
        id_hold_next  = id_dec;
        nfc_hold_next = nfc_dec;
        id_miss_next  = id_miss_reg;
        present_next  = present_reg;
        unique case (mode)
            cspq_pkg::MODE_IC:
            begin
                timer_sel = ic_dec;
                mask_sel  = cspq_pkg::IC_MASK;
                kind      = in_data_reg.rats_capable ? cspq_pkg::KIND_CPU : cspq_pkg::KIND_IC;
                nbytes    = cspq_pkg::IC_NBYTES;
                present_next[cspq_pkg::PRES_IC] = ok;
                if (ok)
                begin
                    ic_hold_next = ic_hold_ticks_reg;
                end
            end
            cspq_pkg::MODE_ID:
            begin
                timer_sel = id_dec;
                mask_sel  = cspq_pkg::ID_MASK;
                kind      = cspq_pkg::KIND_ID;
                nbytes    = cspq_pkg::ID_NBYTES;
                if (ok)
                begin
                    id_hold_next = id_hold_ticks_reg;
                    id_miss_next = id_miss_limit_reg;
                    present_next[cspq_pkg::PRES_ID] = 1'b1;
                end
                else
                begin
                    // Drop ID presence only after the miss countdown runs out
                    id_miss_next = miss_dec;
                    if (miss_dec == 8'd0)
                    begin
                        present_next[cspq_pkg::PRES_ID] = 1'b0;
                    end
                end
            end
            default:
            begin
                timer_sel = nfc_dec;
                mask_sel  = cspq_pkg::NFC_MASK;
                kind      = cspq_pkg::KIND_NFC;
                nbytes    = cspq_pkg::NFC_NBYTES;
                if (ok)
                begin
                    nfc_hold_next = nfc_hold_ticks_reg;
                    if (hit_ev)
                    begin
                        present_next[cspq_pkg::PRES_NFC] = 1'b1;
                    end
                end
                else
                begin
                    present_next[cspq_pkg::PRES_NFC] = 1'b0;
                end
            end
        endcase

        // Replace only the compared bytes of the last UID
        last_uid_next = last_uid_reg;
        if (ok && !uid_same)
        begin
            last_uid_next = (last_uid_reg & ~mask_sel) | (uid & mask_sel);
        end

        out_data_next.scan_mode      = mode;
        out_data_next.card_event     = hit_ev;
        out_data_next.card_kind      = hit_ev ? kind : cspq_pkg::KIND_IC;
        out_data_next.card_bytes     = hit_ev ? nbytes : 4'd0;
        out_data_next.event_uid      = hit_ev ? (uid & mask_sel) : '0;
        out_data_next.presence_flags = present_next;
        priority if (present_reg > present_next)
        begin
            out_data_next.presence_change = cspq_pkg::CHG_EXIT;
        end
        else if (present_reg < present_next)
        begin
            out_data_next.presence_change = cspq_pkg::CHG_ENTER;
        end
        else
        begin
            out_data_next.presence_change = cspq_pkg::CHG_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_hold_reg  <= '0;
            id_hold_reg  <= '0;
            nfc_hold_reg <= '0;
            id_miss_reg  <= '0;
            last_uid_reg <= '0;
            present_reg  <= '0;
        end
        else if (adv)
        begin
            ic_hold_reg  <= ic_hold_next;
            id_hold_reg  <= id_hold_next;
            nfc_hold_reg <= nfc_hold_next;
            id_miss_reg  <= id_miss_next;
            last_uid_reg <= last_uid_next;
            present_reg  <= present_next;
        end
    end

endmodule

FILE: sv/cspq_checker.sv
// ----------------------------------------------------------------------------
// cspq_checker
// Port-level checks on the card scan presence qualifier, bound to the top.
// ----------------------------------------------------------------------------
`include "card_scan_presence_qualifier_defines.svh"

module cspq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input cspq_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_stall,
    input cspq_pkg::out_t out_data,
    input logic           cfg_we,
    input logic [2:0]     cfg_index,
    input logic [7:0]     cfg_data
);

    `CSPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
    `CSPQ_ASSERT_NOW(a_no_event_zero, out_valid && !out_data.card_event, out_data.card_kind == cspq_pkg::KIND_IC && out_data.card_bytes == 4'd0 && out_data.event_uid == '0, "event fields set without event")
    `CSPQ_ASSERT_NOW(a_nfc_event_present, out_valid && out_data.card_event && out_data.scan_mode == cspq_pkg::MODE_NFC, out_data.presence_flags[cspq_pkg::PRES_NFC], "NFC event without NFC presence")
    `CSPQ_ASSERT_NOW(a_ic_kind, out_valid && out_data.card_event && out_data.scan_mode == cspq_pkg::MODE_IC, out_data.card_kind == cspq_pkg::KIND_IC || out_data.card_kind == cspq_pkg::KIND_CPU, "IC event with wrong kind")

endmodule

bind card_scan_presence_qualifier cspq_checker u_cspq_checker (.*);
